[hdl/tmp_pkg.sv]
`default_nettype none
package tmp_pkg;

    localparam int PIX_W = 8;
    localparam int BIT_W = $clog2(PIX_W);

    typedef logic [PIX_W-1:0] t_pix;

    // Per-cycle control from the sequencer to every channel lane
    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic             cmp;
        logic             start;
        logic             pass_end;
        logic [BIT_W-1:0] bit_sel;
    } t_lane_ctl;

endpackage
`default_nettype wire

[hdl/tmp_if.sv]
`default_nettype none
interface tmp_pix_if;
    import tmp_pkg::*;

    logic valid;
    logic ready;
    t_pix blue;
    t_pix green;
    t_pix red;
    logic last_sample;

    modport source (output valid, output blue, output green, output red,
                    output last_sample, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input last_sample, output ready);
endinterface

interface tmp_med_if;
    import tmp_pkg::*;

    logic valid;
    logic ready;
    t_pix median_blue;
    t_pix median_green;
    t_pix median_red;
    logic overflow;

    modport source (output valid, output median_blue, output median_green,
                    output median_red, output overflow, input ready);
    modport sink   (input valid, input median_blue, input median_green,
                    input median_red, input overflow, output ready);
endinterface
`default_nettype wire

[hdl/temporal_median_pixel_unit.sv]
// Samples are taken one word per cycle while a run is collected.
// After the last sample of a run of n stored samples, the three channel lanes run
// eight bitwise rank passes over their sample RAMs; the result word is loaded into
// the output register once the last pass ends and that register is free, and no samples
// are taken meanwhile. The read passes over the sample RAMs set that wait.
// Synchronous active-low reset clears the run count, overflow flag and output valid.
`default_nettype none
module temporal_median_pixel_unit #(
    parameter int MAX_SAMPLES = 64,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tmp_pix_if.sink    i_pix,
    tmp_med_if.source  o_med
);
    import tmp_pkg::*;

    localparam int NUM_LANES = 3;

    t_lane_ctl     w_ctl;
    logic [CW-1:0] w_wr_addr;
    logic [CW-1:0] w_rd_addr;
    logic [CW-1:0] w_rank;
    logic          w_ready;
    logic          w_res_valid;
    logic          w_ovf;
    logic          w_out_free;
    logic          w_load;
    logic          w_acc;
    t_pix          w_pix [NUM_LANES];
    t_pix          w_med [NUM_LANES];

    logic          r_out_valid;
    t_pix          r_med_b;
    t_pix          r_med_g;
    t_pix          r_med_r;
    logic          r_ovf;

    assign w_acc      = i_pix.valid && w_ready;
    assign w_out_free = !r_out_valid || o_med.ready;
    assign w_load     = w_res_valid && w_out_free;

    assign w_pix[0] = i_pix.blue;
    assign w_pix[1] = i_pix.green;
    assign w_pix[2] = i_pix.red;

    tmp_seq #(.MAX_SAMPLES(MAX_SAMPLES)) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_acc),
        .i_last      (i_pix.last_sample),
        .i_out_free  (w_out_free),
        .o_ready     (w_ready),
        .o_res_valid (w_res_valid),
        .o_ovf       (w_ovf),
        .o_ctl       (w_ctl),
        .o_wr_addr   (w_wr_addr),
        .o_rd_addr   (w_rd_addr),
        .o_rank      (w_rank)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        tmp_lane #(.MAX_SAMPLES(MAX_SAMPLES)) u_lane (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_wr_addr (w_wr_addr),
            .i_rd_addr (w_rd_addr),
            .i_rank    (w_rank),
            .i_pix     (w_pix[g]),
            .o_median  (w_med[g])
        );
    end

    // Merge the lane results and the overflow flag into one output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (o_med.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_med_b <= w_med[0];
            r_med_g <= w_med[1];
            r_med_r <= w_med[2];
            r_ovf   <= w_ovf;
        end
    end

    assign i_pix.ready        = w_ready;
    assign o_med.valid        = r_out_valid;
    assign o_med.median_blue  = r_med_b;
    assign o_med.median_green = r_med_g;
    assign o_med.median_red   = r_med_r;
    assign o_med.overflow     = r_ovf;

`ifndef SYNTH
    a_last_stops_intake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && i_pix.last_sample) |=> !i_pix.ready)
        else $error("sample intake open after last sample");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res_valid && !w_out_free) |=> w_res_valid)
        else $error("result dropped while output register busy");

    a_intake_excl_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix.ready |-> !w_res_valid)
        else $error("intake open while result pending");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load |=> (o_med.valid && !w_res_valid))
        else $error("merged result not presented");
`endif
endmodule
`default_nettype wire

[hdl/tmp_ram.sv]
`default_nettype none
module tmp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

[hdl/tmp_lane.sv]
`default_nettype none
module tmp_lane #(
    parameter int MAX_SAMPLES = 64,
    localparam int CW = $clog2(MAX_SAMPLES + 1),
    localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
    input  wire logic               i_clk,
    input  wire tmp_pkg::t_lane_ctl i_ctl,
    input  wire logic [CW-1:0]      i_wr_addr,
    input  wire logic [CW-1:0]      i_rd_addr,
    input  wire logic [CW-1:0]      i_rank,
    input  wire tmp_pkg::t_pix      i_pix,
    output tmp_pkg::t_pix           o_median
);
    import tmp_pkg::*;

    t_pix          w_rd;
    t_pix          w_upper;
    logic          w_match;
    t_pix          r_prefix;
    logic [CW-1:0] r_rank;
    logic [CW-1:0] r_cnt;

    tmp_ram #(.WIDTH(PIX_W), .DEPTH(MAX_SAMPLES)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_wr_addr[AW-1:0]),
        .i_wdata (i_pix),
        .i_re    (i_ctl.rd_en),
        .i_raddr (i_rd_addr[AW-1:0]),
        .o_rdata (w_rd)
    );

    // Entry agrees with the decided upper bits and has a zero at the bit under test
    assign w_upper = {PIX_W{1'b1}} << ({1'b0, i_ctl.bit_sel} + (BIT_W+1)'(1));
    assign w_match = (((w_rd ^ r_prefix) & w_upper) == '0) && !w_rd[i_ctl.bit_sel];

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_prefix <= '0;
            r_rank   <= i_rank;
            r_cnt    <= '0;
        end else if (i_ctl.pass_end) begin
            r_cnt <= '0;
            if (r_cnt <= r_rank) begin
                r_prefix[i_ctl.bit_sel] <= 1'b1;
                r_rank                  <= r_rank - r_cnt;
            end
        end else if (i_ctl.cmp && w_match) begin
            r_cnt <= r_cnt + CW'(1);
        end
    end

    assign o_median = r_prefix;
endmodule
`default_nettype wire

[hdl/tmp_seq.sv]
`default_nettype none
module tmp_seq #(
    parameter int MAX_SAMPLES = 64,
    localparam int CW = $clog2(MAX_SAMPLES + 1)
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_acc,
    input  wire logic          i_last,
    input  wire logic          i_out_free,
    output logic               o_ready,
    output logic               o_res_valid,
    output logic               o_ovf,
    output tmp_pkg::t_lane_ctl o_ctl,
    output logic [CW-1:0]      o_wr_addr,
    output logic [CW-1:0]      o_rd_addr,
    output logic [CW-1:0]      o_rank
);
    import tmp_pkg::*;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_READ,
        S_DRAIN,
        S_DECIDE,
        S_RESULT
    } t_state;

    t_state           r_state;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_addr;
    logic [BIT_W-1:0] r_bit;
    logic             r_drop;
    logic             r_cmp;
    logic             w_room;
    logic [CW-1:0]    w_cnt_next;

    assign w_room     = (r_count < CW'(MAX_SAMPLES));
    assign w_cnt_next = w_room ? (r_count + CW'(1)) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_COLLECT;
            r_count <= '0;
            r_addr  <= '0;
            r_bit   <= '0;
            r_drop  <= 1'b0;
            r_cmp   <= 1'b0;
        end else begin
            r_cmp <= (r_state == S_READ);
            case (r_state)
                S_COLLECT: begin
                    if (i_acc) begin
                        r_count <= w_cnt_next;
                        if (!w_room) begin
                            r_drop <= 1'b1;
                        end
                        if (i_last) begin
                            r_addr  <= '0;
                            r_bit   <= BIT_W'(PIX_W - 1);
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == r_count - CW'(1)) begin
                        r_state <= S_DRAIN;
                    end
                end
                S_DRAIN: begin
                    r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    if (r_bit == '0) begin
                        r_state <= S_RESULT;
                    end else begin
                        r_bit   <= r_bit - BIT_W'(1);
                        r_addr  <= '0;
                        r_state <= S_READ;
                    end
                end
                S_RESULT: begin
                    // hold until the output register takes the word
                    if (i_out_free) begin
                        r_count <= '0;
                        r_drop  <= 1'b0;
                        r_state <= S_COLLECT;
                    end
                end
                default: begin
                    r_state <= S_COLLECT;
                end
            endcase
        end
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.wr_en    = (r_state == S_COLLECT) && i_acc && w_room;
        o_ctl.rd_en    = (r_state == S_READ);
        o_ctl.cmp      = r_cmp;
        o_ctl.start    = (r_state == S_COLLECT) && i_acc && i_last;
        o_ctl.pass_end = (r_state == S_DECIDE);
        o_ctl.bit_sel  = r_bit;
    end

    assign o_ready     = (r_state == S_COLLECT);
    assign o_res_valid = (r_state == S_RESULT);
    assign o_ovf       = r_drop;
    assign o_wr_addr   = r_count;
    assign o_rd_addr   = r_addr;
    assign o_rank      = w_cnt_next >> 1;
endmodule
`default_nettype wire
